// ===== hdl/cing_pkg.sv =====
// shared types, constants and slot decoding for the cell id neighbour generator
package cing_pkg;

  localparam int ID_W     = 64;
  localparam int BOUND_W  = 16;
  localparam int VAL_W    = BOUND_W + 1;
  localparam int NFIELD   = 3;
  localparam int NSLOT    = 26;
  localparam int SLOT_W   = 5;
  localparam int AXIS_SLOTS   = 6;
  localparam int TRIPLE_SLOTS = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int MODE_W     = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_F0_LOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_F0_HIGH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_F1_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_F1_HIGH = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_F2_LOW  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_F2_HIGH = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIAG    = 4'd7;

  localparam logic signed [BOUND_W-1:0] LOW_RESET  = 16'sh0000;
  localparam logic signed [BOUND_W-1:0] HIGH_RESET = 16'sh7FFF;

  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_NONE  = 2'd1,
    ST_OOB   = 2'd2
  } status_t;

  // which fields a candidate slot steps, and in which direction (1 = plus)
  typedef struct packed {
    logic [NFIELD-1:0] used;
    logic [NFIELD-1:0] dir;
  } slot_t;

  // control part of a request handed from the decode stage to the emitter
  typedef struct packed {
    logic             oob;
    logic [NSLOT-1:0] mask;
  } work_ctl_t;

  // slot order: axis steps, then three-field patterns, then field pairs
  function automatic slot_t slot_map(input logic [SLOT_W-1:0] s);
    slot_t            r;
    logic [SLOT_W-1:0] t;
    r = '0;
    t = '0;
    if (s < SLOT_W'(AXIS_SLOTS)) begin
      r.used = NFIELD'(1) << s[SLOT_W-1:1];
      r.dir  = s[0] ? r.used : '0;
    end else if (s < SLOT_W'(AXIS_SLOTS + TRIPLE_SLOTS)) begin
      t      = s - SLOT_W'(AXIS_SLOTS);
      r.used = '1;
      r.dir  = {t[0], t[1], t[2]};
    end else begin
      t = s - SLOT_W'(AXIS_SLOTS + TRIPLE_SLOTS);
      unique case (t[3:2])
        2'd0: begin
          r.used = 3'b011;
          r.dir  = {1'b0, t[0], t[1]};
        end
        2'd1: begin
          r.used = 3'b101;
          r.dir  = {t[0], 1'b0, t[1]};
        end
        2'd2: begin
          r.used = 3'b110;
          r.dir  = {t[0], t[1], 1'b0};
        end
        default: begin
          r.used = '0;
          r.dir  = '0;
        end
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hdl/cing_if.sv =====
// request channels of the cell id neighbour generator
interface cing_in_if import cing_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] cell_id;
  modport source(output valid, output cell_id, input ready);
  modport sink(input valid, input cell_id, output ready);
endinterface

interface cing_out_if import cing_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] neighbour_id;
  status_t         status;
  logic            last;
  modport source(output valid, output neighbour_id, output status, output last, input ready);
  modport sink(input valid, input neighbour_id, input status, input last, output ready);
endinterface

interface cing_cfg_if import cing_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/cing_field_step.sv =====
// bounds check and -1/+1 step of one index field
module cing_field_step import cing_pkg::*; #(
  parameter int FW = 16
) (
  input  logic [FW-1:0]             raw,
  input  logic                      is_signed,
  input  logic                      cyclic,
  input  logic signed [BOUND_W-1:0] low,
  input  logic signed [BOUND_W-1:0] high,
  output logic                      oob,
  output logic                      ok_m,
  output logic                      ok_p,
  output logic [FW-1:0]             val_m,
  output logic [FW-1:0]             val_p
);

  logic signed [VAL_W-1:0] v;
  logic signed [VAL_W-1:0] low_x;
  logic signed [VAL_W-1:0] high_x;
  logic signed [VAL_W-1:0] v_dec;
  logic signed [VAL_W-1:0] v_inc;

  // field value widened, signed or unsigned as configured
  assign v      = {{(VAL_W-FW){is_signed & raw[FW-1]}}, raw};
  assign low_x  = {low[BOUND_W-1], low};
  assign high_x = {high[BOUND_W-1], high};
  assign v_dec  = v - VAL_W'(1);
  assign v_inc  = v + VAL_W'(1);

  assign oob = (v < low_x) || (v > high_x);

  // cyclic fields wrap at the bounds, others stop there
  assign ok_m  = cyclic || (v > low_x);
  assign ok_p  = cyclic || (v < high_x);
  assign val_m = (cyclic && (v == low_x))  ? high[FW-1:0] : v_dec[FW-1:0];
  assign val_p = (cyclic && (v == high_x)) ? low[FW-1:0]  : v_inc[FW-1:0];

endmodule

// ===== hdl/cing_emitter.sv =====
// work register walking the candidate mask, and the result register
module cing_emitter import cing_pkg::*; #(
  parameter int FW         = 16,
  parameter int FIELD0_LSB = 0,
  parameter int FIELD1_LSB = 16,
  parameter int FIELD2_LSB = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  output logic              load_ready,
  input  work_ctl_t         load_ctl,
  input  logic [ID_W-1:0]   load_id,
  input  logic [FW-1:0]     load_minus [NFIELD],
  input  logic [FW-1:0]     load_plus  [NFIELD],
  cing_out_if.source        out_chan
);

  localparam int LSB_OF [NFIELD] = '{FIELD0_LSB, FIELD1_LSB, FIELD2_LSB};

  logic             work_vld_r;
  logic             oob_r;
  logic [NSLOT-1:0] mask_r;
  logic [ID_W-1:0]  id_r;
  logic [FW-1:0]    minus_r [NFIELD];
  logic [FW-1:0]    plus_r  [NFIELD];

  logic             out_vld_r;
  logic [ID_W-1:0]  out_id_r;
  status_t          out_st_r;
  logic             out_last_r;

  logic             emit;
  logic             special;
  logic             done;
  logic [NSLOT-1:0] low_bit;
  logic [NSLOT-1:0] rest;
  logic [SLOT_W-1:0] sel;
  slot_t            sd;
  logic [ID_W-1:0]  nid;
  logic [ID_W-1:0]  res_id;
  status_t          res_st;

  // lowest pending candidate
  always_comb begin
    sel = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = SLOT_W'(i);
      end
    end
  end

  assign low_bit = mask_r & (~mask_r + NSLOT'(1));
  assign rest    = mask_r & ~low_bit;
  assign special = oob_r || (mask_r == '0);
  assign done    = special || (rest == '0);
  assign emit    = work_vld_r && (!out_vld_r || out_chan.ready);
  assign load_ready = !work_vld_r || (emit && done);

  // neighbour id: stepped fields written in order, later ones win
  always_comb begin
    sd  = slot_map(sel);
    nid = id_r;
    for (int f = 0; f < NFIELD; f++) begin
      if (sd.used[f]) begin
        nid[LSB_OF[f] +: FW] = sd.dir[f] ? plus_r[f] : minus_r[f];
      end
    end
  end

  // result selection for the special cases
  always_comb begin
    priority if (oob_r) begin
      res_id = id_r;
      res_st = ST_OOB;
    end else if (mask_r == '0) begin
      res_id = '0;
      res_st = ST_NONE;
    end else begin
      res_id = nid;
      res_st = ST_VALID;
    end
  end

  // work register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_vld_r <= 1'b0;
    end else if (load_valid && load_ready) begin
      work_vld_r <= 1'b1;
    end else if (emit && done) begin
      work_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      oob_r   <= load_ctl.oob;
      mask_r  <= load_ctl.mask;
      id_r    <= load_id;
      minus_r <= load_minus;
      plus_r  <= load_plus;
    end else if (emit) begin
      mask_r <= rest;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_id_r   <= res_id;
      out_st_r   <= res_st;
      out_last_r <= done;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.neighbour_id = out_id_r;
  assign out_chan.status       = out_st_r;
  assign out_chan.last         = out_last_r;

endmodule

// ===== hdl/cell_id_neighbour_generator_top.sv =====
// top level of the cell id neighbour generator
//
// Takes a packed 64-bit cell id on the in_chan channel and returns the ids
// of its neighbours on out_chan, one result per cycle while out_chan is
// ready, last set on the final one. Axis steps of fields 0, 1, 2 come
// first; with diagonals enabled the three-field patterns and then the
// field pairs follow. status tells valid neighbour, no neighbour (single
// result, id 0) or field outside bounds (single result, input id).
// Registers are written through cfg_chan (always ready); write them only
// while no request is in flight, the block itself does not enforce this.
// A request passes the input register, the work register and the result
// register. A cell with k results (1 to 26) holds the work register until
// its last result is emitted; the output register emits one result per
// cycle while out_chan is ready. The next cell is already taken into the
// input register meanwhile, so cells follow without a gap.
// Reset (rst_n low, synchronous) empties all stages and restores bounds
// 0..32767, no wrap, unsigned fields, diagonals off.
// When the receiver stalls, the result holds on the port and work stops;
// in_chan.ready falls once the input register is full.
module cell_id_neighbour_generator_top import cing_pkg::*; #(
  parameter int FIELD_WIDTH = 16,
  parameter int FIELD0_LSB  = 0,
  parameter int FIELD1_LSB  = 16,
  parameter int FIELD2_LSB  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  cing_in_if.sink     in_chan,
  cing_out_if.source  out_chan,
  cing_cfg_if.sink    cfg_chan
);

  localparam int LSB_OF [NFIELD] = '{FIELD0_LSB, FIELD1_LSB, FIELD2_LSB};

  logic signed [BOUND_W-1:0] low_r  [NFIELD];
  logic signed [BOUND_W-1:0] high_r [NFIELD];
  logic [MODE_W-1:0]         mode_r;
  logic                      diag_r;

  logic                      in_vld_r;
  logic [ID_W-1:0]           in_id_r;

  logic                      load_ready;
  logic [NFIELD-1:0]         oob;
  logic [NFIELD-1:0]         ok_m;
  logic [NFIELD-1:0]         ok_p;
  logic [FIELD_WIDTH-1:0]    val_m [NFIELD];
  logic [FIELD_WIDTH-1:0]    val_p [NFIELD];
  logic [NSLOT-1:0]          mask;
  work_ctl_t                 ctl;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int f = 0; f < NFIELD; f++) begin
        low_r[f]  <= LOW_RESET;
        high_r[f] <= HIGH_RESET;
      end
      mode_r <= '0;
      diag_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_F0_LOW:  low_r[0]  <= cfg_chan.data;
        REG_F0_HIGH: high_r[0] <= cfg_chan.data;
        REG_F1_LOW:  low_r[1]  <= cfg_chan.data;
        REG_F1_HIGH: high_r[1] <= cfg_chan.data;
        REG_F2_LOW:  low_r[2]  <= cfg_chan.data;
        REG_F2_HIGH: high_r[2] <= cfg_chan.data;
        REG_MODE:    mode_r    <= cfg_chan.data[MODE_W-1:0];
        REG_DIAG:    diag_r    <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  // input register
  assign in_chan.ready = !in_vld_r || load_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_vld_r <= 1'b1;
    end else if (load_ready) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_id_r <= in_chan.cell_id;
    end
  end

  // per-field bounds check and steps
  for (genvar f = 0; f < NFIELD; f++) begin : g_field
    cing_field_step #(
      .FW(FIELD_WIDTH)
    ) u_step (
      .raw      (in_id_r[LSB_OF[f] +: FIELD_WIDTH]),
      .is_signed(mode_r[NFIELD + f]),
      .cyclic   (mode_r[f]),
      .low      (low_r[f]),
      .high     (high_r[f]),
      .oob      (oob[f]),
      .ok_m     (ok_m[f]),
      .ok_p     (ok_p[f]),
      .val_m    (val_m[f]),
      .val_p    (val_p[f])
    );
  end

  // candidate mask: slots whose fields can all step; diagonals need diag_r
  always_comb begin
    slot_t sd;
    logic  ok;
    sd   = '0;
    ok   = 1'b0;
    mask = '0;
    for (int s = 0; s < NSLOT; s++) begin
      sd = slot_map(SLOT_W'(s));
      ok = 1'b1;
      for (int f = 0; f < NFIELD; f++) begin
        if (sd.used[f]) begin
          ok = ok & (sd.dir[f] ? ok_p[f] : ok_m[f]);
        end
      end
      mask[s] = ok && (diag_r || (s < AXIS_SLOTS));
    end
  end

  assign ctl.oob  = |oob;
  assign ctl.mask = mask;

  cing_emitter #(
    .FW        (FIELD_WIDTH),
    .FIELD0_LSB(FIELD0_LSB),
    .FIELD1_LSB(FIELD1_LSB),
    .FIELD2_LSB(FIELD2_LSB)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_valid(in_vld_r),
    .load_ready(load_ready),
    .load_ctl  (ctl),
    .load_id   (in_id_r),
    .load_minus(val_m),
    .load_plus (val_p),
    .out_chan  (out_chan)
  );

endmodule
